>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define AST_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle of the antecedent
`define AST_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/bps_pkg.sv
// package for the buzzer pattern sequencer: types, codes and pattern tables
package bps_pkg;

  localparam int NOW_W    = 32;
  localparam int MODE_W   = 4;
  localparam int DUTY_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int POS_W    = 5;
  localparam int DUR_W    = 10;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_LOUDNESS   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RUN_PERIOD = 1'd1;

  localparam logic [DUTY_W-1:0]   LOUDNESS_RST   = 8'd128;
  localparam logic [PERIOD_W-1:0] RUN_PERIOD_RST = 16'd10;

  // machine mode codes
  localparam logic [MODE_W-1:0] MODE_IMU      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 4'd12;
  localparam logic [MODE_W-1:0] MODE_NONE     = 4'd14;

  // pattern lengths in entries
  localparam logic [POS_W-1:0] INFO_LEN = 5'd1;
  localparam logic [POS_W-1:0] IMU_LEN  = 5'd23;
  localparam logic [POS_W-1:0] WARN_LEN = 5'd5;

  // entry durations in ms
  localparam logic [DUR_W-1:0] DUR_SHORT = 10'd100;
  localparam logic [DUR_W-1:0] DUR_MID   = 10'd500;
  localparam logic [DUR_W-1:0] DUR_LONG  = 10'd1000;

  typedef enum logic [1:0] {
    PAT_NONE = 2'd0,
    PAT_INFO = 2'd1,
    PAT_IMU  = 2'd2,
    PAT_WARN = 2'd3
  } pat_id_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   loudness;
    logic [PERIOD_W-1:0] run_period_ms;
  } cfg_t;

  typedef struct packed {
    logic              handled;
    logic [DUTY_W-1:0] duty;
    logic              sounding;
  } res_t;

  function automatic logic [POS_W-1:0] pat_len(input pat_id_t id);
    logic [POS_W-1:0] len;
    case (id)
      PAT_INFO: len = INFO_LEN;
      PAT_IMU:  len = IMU_LEN;
      PAT_WARN: len = WARN_LEN;
      default:  len = '0;
    endcase
    return len;
  endfunction

  // on and off entries alternate, so the low position bit picks the duration
  function automatic logic [DUR_W-1:0] pat_dur(input pat_id_t id, input logic [POS_W-1:0] pos);
    logic [DUR_W-1:0] dur;
    case (id)
      PAT_INFO: dur = DUR_LONG;
      PAT_IMU:  dur = pos[0] ? DUR_LONG : DUR_SHORT;
      PAT_WARN: dur = pos[0] ? DUR_LONG : DUR_MID;
      default:  dur = '0;
    endcase
    return dur;
  endfunction

endpackage

>>> src/bps_cfg_regs.sv
// configuration registers: loudness and run period
module bps_cfg_regs
  import bps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_LOUDNESS:   cfg_nxt.loudness      = cfg_wdata[DUTY_W-1:0];
        CFG_RUN_PERIOD: cfg_nxt.run_period_ms = cfg_wdata[PERIOD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loudness      <= LOUDNESS_RST;
      cfg_r.run_period_ms <= RUN_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/bps_seq_core.sv
// sequencing state and the per-poll update
module bps_seq_core
  import bps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [NOW_W-1:0]  now_ms,
  input  logic [MODE_W-1:0] mode_code,
  input  cfg_t              cfg,
  output res_t              res
);

  logic [MODE_W-1:0] last_mode_r, last_mode_nxt;
  pat_id_t           pat_id_r, pat_id_nxt;
  logic [POS_W-1:0]  pat_pos_r, pat_pos_nxt;
  logic              tone_on_r, tone_on_nxt;
  logic [NOW_W-1:0]  entry_end_r, entry_end_nxt;
  logic [NOW_W-1:0]  next_poll_r, next_poll_nxt;

  logic [NOW_W-1:0]  poll_diff;
  logic [NOW_W-1:0]  end_diff;
  logic              handled;
  logic              mode_chg;
  pat_id_t           sel;
  logic              start;
  pat_id_t           id_a;
  logic [POS_W-1:0]  pos_a;
  logic              tone_a;
  logic [NOW_W-1:0]  end_a;
  logic              expired;
  logic              exhausted;

  // poll gate on the wrapping signed difference
  assign poll_diff = now_ms - next_poll_r;
  assign handled   = !poll_diff[NOW_W-1];

  // pattern selection from the mode code
  always_comb begin
    case (mode_code) inside
      [4'd0:4'd6]:  sel = PAT_INFO;
      MODE_IMU:     sel = PAT_IMU;
      [4'd8:4'd11]: sel = PAT_WARN;
      default:      sel = PAT_NONE;
    endcase
  end

  assign mode_chg = (mode_code != last_mode_r) && (last_mode_r != MODE_SHUTDOWN);
  assign start    = mode_chg && (sel != PAT_NONE);

  // state as seen after a possible pattern start
  assign id_a   = start ? sel : pat_id_r;
  assign pos_a  = start ? '0 : pat_pos_r;
  assign tone_a = start ? 1'b0 : tone_on_r;
  assign end_a  = start ? '0 : entry_end_r;

  assign end_diff  = now_ms - end_a;
  assign expired   = !end_diff[NOW_W-1];
  assign exhausted = (pos_a >= pat_len(id_a));

  // entry advance or silence
  always_comb begin
    last_mode_nxt = mode_chg ? mode_code : last_mode_r;
    next_poll_nxt = now_ms + {{(NOW_W-PERIOD_W){1'b0}}, cfg.run_period_ms};
    pat_id_nxt    = id_a;
    pat_pos_nxt   = pos_a;
    tone_on_nxt   = tone_a;
    entry_end_nxt = end_a;
    if (expired) begin
      if (exhausted) begin
        pat_id_nxt    = PAT_NONE;
        pat_pos_nxt   = '0;
        tone_on_nxt   = 1'b0;
        entry_end_nxt = '0;
      end else begin
        tone_on_nxt   = !pos_a[0];
        entry_end_nxt = now_ms + {{(NOW_W-DUR_W){1'b0}}, pat_dur(id_a, pos_a)};
        pat_pos_nxt   = pos_a + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mode_r <= MODE_NONE;
      pat_id_r    <= PAT_NONE;
      pat_pos_r   <= '0;
      tone_on_r   <= 1'b0;
      entry_end_r <= '0;
      next_poll_r <= '0;
    end else if (step_en && handled) begin
      last_mode_r <= last_mode_nxt;
      pat_id_r    <= pat_id_nxt;
      pat_pos_r   <= pat_pos_nxt;
      tone_on_r   <= tone_on_nxt;
      entry_end_r <= entry_end_nxt;
      next_poll_r <= next_poll_nxt;
    end
  end

  assign res.handled  = handled;
  assign res.sounding = tone_on_nxt;
  assign res.duty     = tone_on_nxt ? cfg.loudness : '0;

endmodule

>>> src/buzzer_pattern_sequencer.sv
// top level of the buzzer pattern sequencer: input register, core, output register
// Takes one poll request per cycle unless a stalled output holds the input register, and
// answers a handled poll with one duty result (polls closer together than the run
// period give no result). The poll lands in the input register, then the beep state is
// updated and the result is written to the output register in the same cycle. The full
// update of the sequencing state together with the result is what lets polls follow
// back to back. A stalled output holds the next poll in the input register.
module buzzer_pattern_sequencer
  import bps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms, [35:32] mode_code, rest zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] duty, [8] sounding, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res;

  logic              in_vld_r, in_vld_nxt;
  logic [NOW_W-1:0]  now_r;
  logic [MODE_W-1:0] mode_r;
  logic              out_vld_r, out_vld_nxt;
  logic [DUTY_W-1:0] duty_r;
  logic              sounding_r;
  logic              fire;
  logic              in_acc;

  bps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the held poll is processed whenever the output register can take a result
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  bps_seq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (fire),
    .now_ms    (now_r),
    .mode_code (mode_r),
    .cfg       (cfg),
    .res       (res)
  );

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r  <= in_tdata[NOW_W-1:0];
      mode_r <= in_tdata[NOW_W+MODE_W-1:NOW_W];
    end
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = res.handled;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.handled) begin
      duty_r     <= res.duty;
      sounding_r <= res.sounding;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-DUTY_W-1){1'b0}}, sounding_r, duty_r};

endmodule

>>> src/bps_checker.sv
// port-level checker for the buzzer pattern sequencer and its bind
`include "assert_macros.svh"

module bps_checker
  import bps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [DUTY_W-1:0]            duty;
  logic                         sounding;
  logic [OUT_DATA_W-DUTY_W-2:0] pad;
  logic                         out_stall;

  // result fields and the receiver stall
  assign duty      = out_tdata[DUTY_W-1:0];
  assign sounding  = out_tdata[DUTY_W];
  assign pad       = out_tdata[OUT_DATA_W-1:DUTY_W+1];
  assign out_stall = out_tvalid && !out_tready;

  // a nonzero duty only comes with a sounding entry
  `AST_IMPLY(a_duty_needs_tone, out_tvalid && (duty != '0), sounding, "duty without tone")

  // padding bits of the result stay zero
  `AST_IMPLY(a_pad_zero, out_tvalid, pad == '0, "result padding set")

  // input side stalls only behind a stalled result
  `AST_IMPLY(a_stall_cause, !in_tready, out_stall, "input stalled without output stall")

  // stalled result holds
  `AST_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result dropped")

endmodule

bind buzzer_pattern_sequencer bps_checker u_bps_checker (.*);

>>> sim/testbench.sv
// testbench for the buzzer pattern sequencer: directed and random polls checked by a predictor
module testbench
  import bps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // mode codes not named in the package
  localparam logic [MODE_W-1:0] MODE_BOOT        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_GPS_LAST    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MOW         = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ESCAPE_LAST = 4'd11;
  localparam logic [MODE_W-1:0] MODE_OTHER       = 4'd13;
  localparam logic [MODE_W-1:0] MODE_SPARE       = 4'd15;

  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_POLLS    = 240;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              sounding;
  } beep_t;

  typedef struct packed {
    logic [NOW_W-1:0]  now;
    logic [MODE_W-1:0] mode;
    logic              known;     // expectation typed into the row
    logic              hit;       // typed: poll is handled
    logic [DUTY_W-1:0] duty;
    logic              sounding;
  } poll_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] now_ms, [35:32] mode_code, rest zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] duty, [8] sounding, rest zero
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  buzzer_pattern_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers and the beep state
  logic [DUTY_W-1:0]   loudness_cfg = LOUDNESS_RST;
  logic [PERIOD_W-1:0] period_cfg   = RUN_PERIOD_RST;
  logic [MODE_W-1:0]   stored_mode  = MODE_NONE;
  pat_id_t             cur_pat      = PAT_NONE;
  logic [POS_W-1:0]    pat_pos      = '0;
  logic                tone         = 1'b0;
  logic [NOW_W-1:0]    entry_end    = '0;
  logic [NOW_W-1:0]    next_poll    = '0;

  beep_t beep_q[$];

  int  errors = 0;
  int  polls_sent = 0;
  int  results_seen = 0;
  int  settings_used = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  logic [NOW_W-1:0]  clock_ms = '0;
  logic [MODE_W-1:0] cur_mode = MODE_IDLE;

  poll_row_t directed_rows [20] = '{
    '{32'd0,          MODE_NONE,        1'b1, 1'b1, 8'd0,   1'b0},  // first poll, no mode change
    '{32'd5,          MODE_BOOT,        1'b1, 1'b0, 8'd0,   1'b0},  // inside the run period
    '{32'd10,         MODE_IDLE,        1'b1, 1'b1, 8'd128, 1'b1},  // info beep starts
    '{32'd15,         MODE_IDLE,        1'b1, 1'b0, 8'd0,   1'b0},
    '{32'd20,         MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd1010,       MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},  // info exhausted
    '{32'd1020,       MODE_IMU,         1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd1120,       MODE_IMU,         1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd2120,       MODE_IMU,         1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd2130,       MODE_MOW,         1'b0, 1'b0, 8'd0,   1'b0},  // warning restarts pattern
    '{32'd2630,       MODE_MOW,         1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd2640,       MODE_OTHER,       1'b0, 1'b0, 8'd0,   1'b0},  // only updates stored mode
    '{32'd2650,       MODE_SPARE,       1'b0, 1'b0, 8'd0,   1'b0},
    '{32'd2660,       MODE_NONE,        1'b0, 1'b0, 8'd0,   1'b0},
    '{32'h7FFF_FFF0,  MODE_ESCAPE_LAST, 1'b0, 1'b0, 8'd0,   1'b0},
    '{32'h8000_0000,  MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},  // start deferred, upper half
    '{32'hFFFF_FFF0,  MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},
    '{32'hFFFF_FFFF,  MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},
    '{32'h0000_0009,  MODE_IDLE,        1'b0, 1'b0, 8'd0,   1'b0},  // time wrapped, beep starts
    '{32'h0000_0008,  MODE_BOOT,        1'b0, 1'b0, 8'd0,   1'b0}   // time went backwards
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
  endtask

  // wrapping signed difference a - b is not negative
  function automatic bit time_reached(input logic [NOW_W-1:0] a, input logic [NOW_W-1:0] b);
    logic [NOW_W-1:0] diff;
    diff = a - b;
    return !diff[NOW_W-1];
  endfunction

  task automatic go_quiet();
    tone = 1'b0;
    cur_pat = PAT_NONE;
    pat_pos = '0;
    entry_end = '0;
  endtask

  // one poll through the beep state; handled tells whether a duty result follows
  task automatic step_beeper(input logic [NOW_W-1:0] now, input logic [MODE_W-1:0] mode,
                             output bit handled, output beep_t res);
    pat_id_t          sel;
    logic [POS_W-1:0] len;
    logic [DUR_W-1:0] dur;
    handled = 1'b0;
    res = '0;
    sel = PAT_NONE;
    if (time_reached(now, next_poll)) begin
      handled = 1'b1;
      next_poll = now + NOW_W'(period_cfg);
      // mode change, unless shutdown has latched
      if (mode != stored_mode && stored_mode != MODE_SHUTDOWN) begin
        stored_mode = mode;
        if (mode <= MODE_GPS_LAST) sel = PAT_INFO;
        else if (mode == MODE_IMU) sel = PAT_IMU;
        else if (mode <= MODE_ESCAPE_LAST) sel = PAT_WARN;
        if (sel != PAT_NONE) begin
          go_quiet();
          cur_pat = sel;
        end
      end
      // entry expiry: load next entry or go silent
      if (time_reached(now, entry_end)) begin
        case (cur_pat)
          PAT_INFO: len = INFO_LEN;
          PAT_IMU:  len = IMU_LEN;
          PAT_WARN: len = WARN_LEN;
          default:  len = '0;
        endcase
        if (pat_pos >= len) begin
          go_quiet();
        end else begin
          tone = !pat_pos[0];
          case (cur_pat)
            PAT_INFO: dur = DUR_LONG;
            PAT_IMU:  dur = pat_pos[0] ? DUR_LONG : DUR_SHORT;
            PAT_WARN: dur = pat_pos[0] ? DUR_LONG : DUR_MID;
            default:  dur = '0;
          endcase
          entry_end = now + NOW_W'(dur);
          pat_pos = pat_pos + 1'b1;
        end
      end
      res.duty = tone ? loudness_cfg : '0;
      res.sounding = tone;
    end
  endtask

  // offer one poll request from a falling edge, return at the falling edge after acceptance
  task automatic drive_poll(input logic [NOW_W-1:0] now, input logic [MODE_W-1:0] mode,
                            output bit handled, output beep_t res);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - NOW_W - MODE_W){1'b0}}, mode, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
    step_beeper(now, mode, handled, res);
    @(negedge clk);
  endtask

  // wait until every expected result is back and the pipe has emptied
  task automatic wait_for_quiet();
    while (beep_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [DUTY_W-1:0] loud, input logic [PERIOD_W-1:0] period);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_LOUDNESS;
    cfg_wdata <= CFG_DATA_W'(loud);
    @(negedge clk);
    cfg_addr <= CFG_RUN_PERIOD;
    cfg_wdata <= period;
    @(negedge clk);
    cfg_we <= 1'b0;
    loudness_cfg = loud;
    period_cfg = period;
    settings_used++;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(input bit allow_shutdown);
    logic [MODE_W-1:0] m;
    m = MODE_W'($urandom_range(0, 15));
    if (!allow_shutdown && m == MODE_SHUTDOWN) m = MODE_OTHER;
    return m;
  endfunction

  // mostly steadily advancing time with rare mode changes; some stale polls and jumps
  task automatic random_polls(input int count, input bit allow_shutdown);
    int               kind;
    int               span;
    bit               handled;
    beep_t            res;
    logic [NOW_W-1:0] now;
    logic [MODE_W-1:0] mode;
    span = 2 * int'(period_cfg);
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        if ($urandom_range(0, 4) == 0) clock_ms = clock_ms + $urandom_range(100, 1100);
        else clock_ms = clock_ms + $urandom_range(0, span);
        if ($urandom_range(0, 99) < 8) cur_mode = pick_mode(allow_shutdown);
        now = clock_ms;
        mode = cur_mode;
      end else if (kind < 92) begin
        now = clock_ms - $urandom_range(1, 50);
        mode = pick_mode(allow_shutdown);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 32'h7FFF_FFFF);
        now = clock_ms;
        mode = cur_mode;
      end
      drive_poll(now, mode, handled, res);
      if (handled) beep_q.push_back(res);
    end
  endtask

  // receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    beep_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (beep_q.size() == 0) begin
        report_mismatch("result with no poll waiting", int'(out_tdata), -1);
      end else begin
        want = beep_q.pop_front();
        if (out_tdata[DUTY_W-1:0] !== want.duty)
          report_mismatch("duty", int'(out_tdata[DUTY_W-1:0]), int'(want.duty));
        if (out_tdata[DUTY_W] !== want.sounding)
          report_mismatch("sounding", int'(out_tdata[DUTY_W]), int'(want.sounding));
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles with no request accepted", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    bit    handled;
    beep_t res;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at reset register values
    foreach (directed_rows[i]) begin
      drive_poll(directed_rows[i].now, directed_rows[i].mode, handled, res);
      if (directed_rows[i].known) begin
        if (directed_rows[i].hit)
          beep_q.push_back('{directed_rows[i].duty, directed_rows[i].sounding});
      end else if (handled) begin
        beep_q.push_back(res);
      end
    end
    in_tvalid <= 1'b0;
    clock_ms = 32'd40;
    cur_mode = MODE_IDLE;

    // random phases over several register settings, extremes first
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_quiet();
      case (phase)
        0: write_regs(8'd255, 16'd1);
        1: write_regs(8'd0, 16'hFFFF);
        2: write_regs(DUTY_W'($urandom_range(0, 255)), 16'd0);
        3: write_regs(DUTY_W'($urandom_range(0, 255)), PERIOD_W'($urandom_range(1, 200)));
        4: write_regs(8'd1, 16'd10);
        5: write_regs(DUTY_W'($urandom_range(0, 255)), PERIOD_W'($urandom_range(1, 50)));
        default: write_regs(DUTY_W'($urandom_range(0, 255)), RUN_PERIOD_RST);
      endcase
      // one phase without idling, starting with a long receiver hold-off
      no_idle = (phase == 3);
      if (phase == 3) hold_requests++;
      random_polls(PHASE_POLLS, phase == 6);
      in_tvalid <= 1'b0;
    end
    no_idle = 1'b0;

    wait_for_quiet();
    if (beep_q.size() != 0) report_mismatch("results still expected", 0, beep_q.size());
    $display("sent %0d polls over %0d register settings, %0d duty results compared",
             polls_sent, settings_used, results_seen);
    $display("mode changes, pattern expiry, time wrap, stale polls and shutdown latch exercised");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> buzzer_pattern_sequencer.f
+incdir+src
src/bps_pkg.sv
src/bps_cfg_regs.sv
src/bps_seq_core.sv
src/buzzer_pattern_sequencer.sv
src/bps_checker.sv
sim/testbench.sv
